/* hw/rtl/lcae_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcae_pkg
// shared types, codes and defaults of the lowest common ancestor engine
// ----------------------------------------------------------------------------
package lcae_pkg;

  localparam int unsigned MAX_NODES_DEF  = 1024;
  localparam int unsigned LOG_LEVELS_DEF = 10;
  localparam int unsigned NODE_IO_W      = 10;
  localparam int unsigned CNT_W          = 10;

  typedef enum logic [1:0] {
    OPC_CLEAR = 2'd0,
    OPC_LOAD  = 2'd1,
    OPC_BUILD = 2'd2,
    OPC_QUERY = 2'd3
  } opcode_e;

  typedef struct packed {
    opcode_e                opcode;
    logic [NODE_IO_W-1:0]   node_a;
    logic [NODE_IO_W-1:0]   node_b;
  } req_t;

  typedef struct packed {
    logic [NODE_IO_W-1:0]   ancestor;
    logic                   status;
  } rsp_t;

  // datapath micro operations
  typedef enum logic [4:0] {
    OP_NONE,
    OP_ACCEPT,
    OP_CLR_INIT,
    OP_CLR_STEP,
    OP_LOAD,
    OP_BAD,
    OP_BLD_INIT,
    OP_RD_IDX,
    OP_RD_UP,
    OP_BLD_WR,
    OP_DEP_INIT,
    OP_DX_INIT,
    OP_RD_X,
    OP_DX_STEP,
    OP_DEP_WR,
    OP_Q_INIT,
    OP_Q_DA,
    OP_Q_DB,
    OP_RD_V,
    OP_LIFT,
    OP_RES_U,
    OP_RD_U,
    OP_RD_V_KEEP,
    OP_CLIMB,
    OP_RES_ROW,
    OP_EMIT
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
  } dp_cmd_t;

  typedef struct packed {
    opcode_e opc;
    logic    range_ok;
    logic    idx_end;
    logic    idx_last;
    logic    cnt_zero;
    logic    lvl_bld_last;
    logic    lvl_zero;
    logic    lvl_top;
    logic    uv_equal;
    logic    out_busy;
  } dp_status_t;

  typedef enum logic [4:0] {
    S_BOOT,
    S_CLR,
    S_IDLE,
    S_DEC,
    S_B_RD,
    S_B_UP,
    S_B_WR,
    S_D_INIT,
    S_D_NODE,
    S_D_RD,
    S_D_STEP,
    S_D_WR,
    S_Q_DA,
    S_Q_DB,
    S_L_RD,
    S_L_USE,
    S_CMP,
    S_C_RDU,
    S_C_RDV,
    S_C_USE,
    S_F_RD,
    S_F_USE,
    S_RESP
  } ctrl_state_e;

endpackage

/* hw/rtl/lowest_common_ancestor_engine_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lowest_common_ancestor_engine_top
// binary lifting lowest common ancestor engine over a loaded parent tree
// ----------------------------------------------------------------------------
//  channel   direction  handshake                  payload
//  request   in         in_valid_i / in_ready_o    in_req_i  (opcode, node_a, node_b)
//  result    out        out_valid_o / out_ready_i  out_rsp_o (ancestor, status)
//  config    in         cfg_we_i (no wait)         cfg_wdata_i (node_count)
//
//  one request at a time; every table access goes through the single read
//  port of the ancestor row memory, one row per cycle
//  clear request and reset: a clearing pass over both memories, no request
//  taken meanwhile
//  a stalled result sits in the output register; the next request is still
//  taken and worked, but its result waits until the register is handed over
// ----------------------------------------------------------------------------
module lowest_common_ancestor_engine_top #(
  parameter int unsigned MAX_NODES  = lcae_pkg::MAX_NODES_DEF,
  parameter int unsigned LOG_LEVELS = lcae_pkg::LOG_LEVELS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [lcae_pkg::CNT_W-1:0]   cfg_wdata_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  lcae_pkg::req_t               in_req_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output lcae_pkg::rsp_t               out_rsp_o
);

  // command and status between sequencer and datapath
  lcae_pkg::dp_cmd_t    cmd;
  lcae_pkg::dp_status_t status;

  lcae_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // tables, walk registers and the output register
  lcae_dpath #(
    .MAX_NODES  (MAX_NODES),
    .LOG_LEVELS (LOG_LEVELS)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_req_i    (in_req_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .out_rsp_o   (out_rsp_o)
  );

endmodule

/* hw/rtl/lcae_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcae_ctrl
// sequencer that steps the datapath through clear, load, build and query
// ----------------------------------------------------------------------------
module lcae_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  lcae_pkg::dp_status_t   status_i,
  output lcae_pkg::dp_cmd_t      cmd_o
);

  lcae_pkg::ctrl_state_e state_q, state_d;
  logic pend_q, pend_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lcae_pkg::S_BOOT;
      pend_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      pend_q  <= pend_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    pend_d  = pend_q;
    case (state_q)
      lcae_pkg::S_BOOT: state_d = lcae_pkg::S_CLR;
      lcae_pkg::S_CLR: begin
        if (status_i.idx_end) begin
          state_d = pend_q ? lcae_pkg::S_RESP : lcae_pkg::S_IDLE;
          pend_d  = 1'b0;
        end
      end
      lcae_pkg::S_IDLE: begin
        if (in_valid_i) state_d = lcae_pkg::S_DEC;
      end
      lcae_pkg::S_DEC: begin
        case (status_i.opc)
          lcae_pkg::OPC_CLEAR: begin
            state_d = lcae_pkg::S_CLR;
            pend_d  = 1'b1;
          end
          lcae_pkg::OPC_LOAD:  state_d = lcae_pkg::S_RESP;
          lcae_pkg::OPC_BUILD: state_d = status_i.cnt_zero ? lcae_pkg::S_RESP
                                                          : lcae_pkg::S_B_RD;
          lcae_pkg::OPC_QUERY: state_d = status_i.range_ok ? lcae_pkg::S_Q_DA
                                                          : lcae_pkg::S_RESP;
          default:             state_d = lcae_pkg::S_RESP;
        endcase
      end
      lcae_pkg::S_B_RD: state_d = lcae_pkg::S_B_UP;
      lcae_pkg::S_B_UP: state_d = lcae_pkg::S_B_WR;
      lcae_pkg::S_B_WR: begin
        state_d = (status_i.idx_last && status_i.lvl_bld_last) ? lcae_pkg::S_D_INIT
                                                               : lcae_pkg::S_B_RD;
      end
      lcae_pkg::S_D_INIT: state_d = lcae_pkg::S_D_NODE;
      lcae_pkg::S_D_NODE: state_d = lcae_pkg::S_D_RD;
      lcae_pkg::S_D_RD:   state_d = lcae_pkg::S_D_STEP;
      lcae_pkg::S_D_STEP: state_d = status_i.lvl_zero ? lcae_pkg::S_D_WR : lcae_pkg::S_D_RD;
      lcae_pkg::S_D_WR:   state_d = status_i.idx_last ? lcae_pkg::S_RESP : lcae_pkg::S_D_NODE;
      lcae_pkg::S_Q_DA:   state_d = lcae_pkg::S_Q_DB;
      lcae_pkg::S_Q_DB:   state_d = lcae_pkg::S_L_RD;
      lcae_pkg::S_L_RD:   state_d = lcae_pkg::S_L_USE;
      lcae_pkg::S_L_USE:  state_d = status_i.lvl_top ? lcae_pkg::S_CMP : lcae_pkg::S_L_RD;
      lcae_pkg::S_CMP:    state_d = status_i.uv_equal ? lcae_pkg::S_RESP : lcae_pkg::S_C_RDU;
      lcae_pkg::S_C_RDU:  state_d = lcae_pkg::S_C_RDV;
      lcae_pkg::S_C_RDV:  state_d = lcae_pkg::S_C_USE;
      lcae_pkg::S_C_USE:  state_d = status_i.lvl_zero ? lcae_pkg::S_F_RD : lcae_pkg::S_C_RDU;
      lcae_pkg::S_F_RD:   state_d = lcae_pkg::S_F_USE;
      lcae_pkg::S_F_USE:  state_d = lcae_pkg::S_RESP;
      lcae_pkg::S_RESP: begin
        if (!status_i.out_busy) state_d = lcae_pkg::S_IDLE;
      end
      default: state_d = lcae_pkg::S_BOOT;
    endcase
  end

  // outputs
  always_comb begin
    cmd_o.op   = lcae_pkg::OP_NONE;
    in_ready_o = 1'b0;
    case (state_q)
      lcae_pkg::S_BOOT: cmd_o.op = lcae_pkg::OP_CLR_INIT;
      lcae_pkg::S_CLR:  cmd_o.op = lcae_pkg::OP_CLR_STEP;
      lcae_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) cmd_o.op = lcae_pkg::OP_ACCEPT;
      end
      lcae_pkg::S_DEC: begin
        case (status_i.opc)
          lcae_pkg::OPC_CLEAR: cmd_o.op = lcae_pkg::OP_CLR_INIT;
          lcae_pkg::OPC_LOAD:  cmd_o.op = status_i.range_ok ? lcae_pkg::OP_LOAD
                                                           : lcae_pkg::OP_BAD;
          lcae_pkg::OPC_BUILD: cmd_o.op = status_i.cnt_zero ? lcae_pkg::OP_NONE
                                                           : lcae_pkg::OP_BLD_INIT;
          lcae_pkg::OPC_QUERY: cmd_o.op = status_i.range_ok ? lcae_pkg::OP_Q_INIT
                                                           : lcae_pkg::OP_BAD;
          default:             cmd_o.op = lcae_pkg::OP_NONE;
        endcase
      end
      lcae_pkg::S_B_RD:   cmd_o.op = lcae_pkg::OP_RD_IDX;
      lcae_pkg::S_B_UP:   cmd_o.op = lcae_pkg::OP_RD_UP;
      lcae_pkg::S_B_WR:   cmd_o.op = lcae_pkg::OP_BLD_WR;
      lcae_pkg::S_D_INIT: cmd_o.op = lcae_pkg::OP_DEP_INIT;
      lcae_pkg::S_D_NODE: cmd_o.op = lcae_pkg::OP_DX_INIT;
      lcae_pkg::S_D_RD:   cmd_o.op = lcae_pkg::OP_RD_X;
      lcae_pkg::S_D_STEP: cmd_o.op = lcae_pkg::OP_DX_STEP;
      lcae_pkg::S_D_WR:   cmd_o.op = lcae_pkg::OP_DEP_WR;
      lcae_pkg::S_Q_DA:   cmd_o.op = lcae_pkg::OP_Q_DA;
      lcae_pkg::S_Q_DB:   cmd_o.op = lcae_pkg::OP_Q_DB;
      lcae_pkg::S_L_RD:   cmd_o.op = lcae_pkg::OP_RD_V;
      lcae_pkg::S_L_USE:  cmd_o.op = lcae_pkg::OP_LIFT;
      lcae_pkg::S_CMP:    cmd_o.op = status_i.uv_equal ? lcae_pkg::OP_RES_U : lcae_pkg::OP_NONE;
      lcae_pkg::S_C_RDU:  cmd_o.op = lcae_pkg::OP_RD_U;
      lcae_pkg::S_C_RDV:  cmd_o.op = lcae_pkg::OP_RD_V_KEEP;
      lcae_pkg::S_C_USE:  cmd_o.op = lcae_pkg::OP_CLIMB;
      lcae_pkg::S_F_RD:   cmd_o.op = lcae_pkg::OP_RD_U;
      lcae_pkg::S_F_USE:  cmd_o.op = lcae_pkg::OP_RES_ROW;
      lcae_pkg::S_RESP: begin
        if (!status_i.out_busy) cmd_o.op = lcae_pkg::OP_EMIT;
      end
      default: cmd_o.op = lcae_pkg::OP_NONE;
    endcase
  end

endmodule

/* hw/rtl/lcae_dpath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcae_dpath
// ancestor table, depth store, walk registers and output register
// ----------------------------------------------------------------------------
module lcae_dpath #(
  parameter int unsigned MAX_NODES  = lcae_pkg::MAX_NODES_DEF,
  parameter int unsigned LOG_LEVELS = lcae_pkg::LOG_LEVELS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [lcae_pkg::CNT_W-1:0]   cfg_wdata_i,
  input  lcae_pkg::req_t               in_req_i,
  input  lcae_pkg::dp_cmd_t            cmd_i,
  output lcae_pkg::dp_status_t         status_o,
  input  logic                         out_ready_i,
  output logic                         out_valid_o,
  output lcae_pkg::rsp_t               out_rsp_o
);

  localparam int unsigned NW  = $clog2(MAX_NODES);
  localparam int unsigned LW  = $clog2(LOG_LEVELS);
  localparam int unsigned DW  = LOG_LEVELS;
  localparam int unsigned RW  = NW * LOG_LEVELS;
  localparam int unsigned CW  = ((NW > lcae_pkg::CNT_W) ? NW : lcae_pkg::CNT_W) + 1;
  localparam logic [NW-1:0] NODE_LAST = NW'(MAX_NODES - 1);
  localparam logic [LW-1:0] LVL_TOP   = LW'(LOG_LEVELS - 1);
  localparam logic [LW-1:0] LVL_BLD   = LW'(LOG_LEVELS - 2);

  logic [RW-1:0] tbl_mem [MAX_NODES];
  logic [DW-1:0] dep_mem [MAX_NODES];

  logic [lcae_pkg::CNT_W-1:0] cnt_q;
  lcae_pkg::opcode_e opc_q;
  logic              range_q;
  logic [NW-1:0]     a_q, b_q, idx_q, x_q, up_q, u_q, v_q, ru_q, res_anc_q;
  logic [LW-1:0]     lvl_q;
  logic [DW-1:0]     d_q, da_q, diff_q, dep_q;
  logic [RW-1:0]     row_q;
  logic              res_st_q;
  logic              out_valid_q;
  lcae_pkg::rsp_t    out_rsp_q;

  logic [NW-1:0]     last;
  logic [CW-1:0]     cnt_ext;
  logic              a_ok, b_ok;
  logic [NW-1:0]     row_fld, raddr;
  logic              tbl_re;
  logic [NW-1:0]     daddr;

  function automatic logic [NW-1:0] fld(input logic [RW-1:0] r, input logic [LW-1:0] l);
    return r[l*NW +: NW];
  endfunction

  assign cnt_ext = CW'(cnt_q);
  assign last    = (cnt_ext > CW'(MAX_NODES - 1)) ? NODE_LAST : NW'(cnt_q);
  assign a_ok    = (in_req_i.node_a != '0) && (CW'(in_req_i.node_a) <= cnt_ext)
                   && (CW'(in_req_i.node_a) < CW'(MAX_NODES));
  assign b_ok    = (in_req_i.node_b != '0) && (CW'(in_req_i.node_b) <= cnt_ext)
                   && (CW'(in_req_i.node_b) < CW'(MAX_NODES));
  assign row_fld = fld(row_q, lvl_q);

  // table read address
  always_comb begin
    tbl_re = 1'b1;
    case (cmd_i.op)
      lcae_pkg::OP_RD_IDX:                       raddr = idx_q;
      lcae_pkg::OP_RD_UP:                        raddr = row_fld;
      lcae_pkg::OP_RD_X:                         raddr = x_q;
      lcae_pkg::OP_RD_V, lcae_pkg::OP_RD_V_KEEP: raddr = v_q;
      lcae_pkg::OP_RD_U:                         raddr = u_q;
      default: begin
        raddr  = idx_q;
        tbl_re = 1'b0;
      end
    endcase
  end

  assign daddr = (cmd_i.op == lcae_pkg::OP_Q_DA) ? b_q : a_q;

  // ancestor table, one row per node holding every level
  always_ff @(posedge clk_i) begin
    if (cmd_i.op == lcae_pkg::OP_CLR_STEP) begin
      tbl_mem[idx_q] <= '0;
    end else if (cmd_i.op == lcae_pkg::OP_LOAD) begin
      tbl_mem[b_q][NW-1:0] <= a_q;
    end else if (cmd_i.op == lcae_pkg::OP_BLD_WR) begin
      tbl_mem[idx_q][(lvl_q + LW'(1))*NW +: NW] <= (up_q != '0) ? row_fld : '0;
    end
    if (tbl_re) begin
      row_q <= tbl_mem[raddr];
    end
  end

  // depth store
  always_ff @(posedge clk_i) begin
    if (cmd_i.op == lcae_pkg::OP_CLR_STEP) begin
      dep_mem[idx_q] <= '0;
    end else if (cmd_i.op == lcae_pkg::OP_DEP_WR) begin
      dep_mem[idx_q] <= d_q;
    end
    dep_q <= dep_mem[daddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= lcae_pkg::CNT_W'(1);
    end else if (cfg_we_i) begin
      cnt_q <= cfg_wdata_i;
    end
  end

  // walk registers
  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      lcae_pkg::OP_ACCEPT: begin
        opc_q     <= in_req_i.opcode;
        range_q   <= a_ok && b_ok;
        a_q       <= NW'(in_req_i.node_a);
        b_q       <= NW'(in_req_i.node_b);
        res_anc_q <= '0;
        res_st_q  <= 1'b0;
      end
      lcae_pkg::OP_CLR_INIT: idx_q <= '0;
      lcae_pkg::OP_CLR_STEP: idx_q <= idx_q + NW'(1);
      lcae_pkg::OP_BAD:      res_st_q <= 1'b1;
      lcae_pkg::OP_BLD_INIT: begin
        lvl_q <= '0;
        idx_q <= NW'(1);
      end
      lcae_pkg::OP_RD_UP: up_q <= row_fld;
      lcae_pkg::OP_BLD_WR: begin
        if (idx_q == last) begin
          idx_q <= NW'(1);
          lvl_q <= lvl_q + LW'(1);
        end else begin
          idx_q <= idx_q + NW'(1);
        end
      end
      lcae_pkg::OP_DEP_INIT: idx_q <= NW'(1);
      lcae_pkg::OP_DX_INIT: begin
        x_q   <= idx_q;
        d_q   <= '0;
        lvl_q <= LVL_TOP;
      end
      lcae_pkg::OP_DX_STEP: begin
        if (row_fld != '0) begin
          x_q <= row_fld;
          d_q <= d_q | (DW'(1) << lvl_q);
        end
        if (lvl_q != '0) lvl_q <= lvl_q - LW'(1);
      end
      lcae_pkg::OP_DEP_WR: idx_q <= idx_q + NW'(1);
      lcae_pkg::OP_Q_INIT: begin
        u_q <= a_q;
        v_q <= b_q;
      end
      lcae_pkg::OP_Q_DA: da_q <= dep_q;
      lcae_pkg::OP_Q_DB: begin
        // keep the deeper node in v
        if (da_q > dep_q) begin
          u_q    <= v_q;
          v_q    <= u_q;
          diff_q <= da_q - dep_q;
        end else begin
          diff_q <= dep_q - da_q;
        end
        lvl_q <= '0;
      end
      lcae_pkg::OP_LIFT: begin
        if (diff_q[lvl_q]) v_q <= row_fld;
        if (lvl_q != LVL_TOP) lvl_q <= lvl_q + LW'(1);
      end
      lcae_pkg::OP_RES_U:     res_anc_q <= u_q;
      lcae_pkg::OP_RD_V_KEEP: ru_q <= row_fld;
      lcae_pkg::OP_CLIMB: begin
        if (ru_q != row_fld) begin
          u_q <= ru_q;
          v_q <= row_fld;
        end
        if (lvl_q != '0) lvl_q <= lvl_q - LW'(1);
      end
      lcae_pkg::OP_RES_ROW: res_anc_q <= fld(row_q, '0);
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.op == lcae_pkg::OP_EMIT) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == lcae_pkg::OP_EMIT) begin
      out_rsp_q.ancestor <= lcae_pkg::NODE_IO_W'(res_anc_q);
      out_rsp_q.status   <= res_st_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;

  assign status_o.opc          = opc_q;
  assign status_o.range_ok     = range_q;
  assign status_o.idx_end      = (idx_q == NODE_LAST);
  assign status_o.idx_last     = (idx_q == last);
  assign status_o.cnt_zero     = (last == '0);
  assign status_o.lvl_bld_last = (lvl_q == LVL_BLD);
  assign status_o.lvl_zero     = (lvl_q == '0);
  assign status_o.lvl_top      = (lvl_q == LVL_TOP);
  assign status_o.uv_equal     = (u_q == v_q);
  assign status_o.out_busy     = out_valid_q && !out_ready_i;

endmodule

/* hw/rtl/lcae_chk.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcae_chk
// port level checks of the lowest common ancestor engine
// ----------------------------------------------------------------------------
module lcae_chk (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         cfg_we_i,
  input logic [lcae_pkg::CNT_W-1:0]   cfg_wdata_i,
  input logic                         in_valid_i,
  input logic                         in_ready_o,
  input lcae_pkg::req_t               in_req_i,
  input logic                         out_valid_o,
  input logic                         out_ready_i,
  input lcae_pkg::rsp_t               out_rsp_o
);

  // a result waits until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_rsp_o))
    else $error("result dropped while stalled");

  // one request at a time
  a_busy_after_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("request taken while busy");

  // a flagged result carries no ancestor
  a_flag_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_rsp_o.status |-> out_rsp_o.ancestor == '0)
    else $error("flagged result with ancestor");

  // ready is not offered again right after a taken request while a result stalls
  a_no_ready_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !(out_valid_o && $past(out_valid_o && !out_ready_i) && !out_ready_i
                     && $past(in_valid_i && in_ready_o, 1)))
    else $error("ready with stalled result after request");

endmodule

bind lowest_common_ancestor_engine_top lcae_chk u_lcae_chk (.*);
